// ===== rtl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key set package
// Shared types and codes for the sorted key set table and its submodules.
// ----------------------------------------------------------------------------
package sks_pkg;

   localparam int KEY_W            = 32;
   localparam int CAPACITY_DEFAULT = 64;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_DELETED   = 3'd3;
   localparam logic [2:0] ST_ABSENT    = 3'd4;
   localparam logic [2:0] ST_FOUND     = 3'd5;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       present;
      logic [6:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SRCH_RD,
      SEQ_SRCH_CMP,
      SEQ_DECIDE,
      SEQ_SHIFT_RD,
      SEQ_SHIFT_WR,
      SEQ_WRITE_KEY
   } seq_state_type;

endpackage

// ===== rtl/sks_key_store.sv =====
// ----------------------------------------------------------------------------
// Sorted key set key store
// Single write port, single registered read port memory for the keys.
// ----------------------------------------------------------------------------
module sks_key_store #(
   parameter int DEPTH = sks_pkg::CAPACITY_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  sks_pkg::mem_ctl_type            ctl,
   input  logic [AW-1:0]                   rd_addr,
   input  logic [AW-1:0]                   wr_addr,
   input  logic signed [sks_pkg::KEY_W-1:0] wr_data,
   output logic signed [sks_pkg::KEY_W-1:0] rd_data
);

   logic signed [sks_pkg::KEY_W-1:0] mem [DEPTH];
   logic signed [sks_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sks_compare.sv =====
// ----------------------------------------------------------------------------
// Sorted key set compare unit
// Signed two's complement compare of a stored key against the request key.
// ----------------------------------------------------------------------------
module sks_compare (
   input  logic signed [sks_pkg::KEY_W-1:0] stored_key,
   input  logic signed [sks_pkg::KEY_W-1:0] probe_key,
   output sks_pkg::cmp_type                 result
);

   always_comb begin
      result.lt = (stored_key < probe_key);
      result.eq = (stored_key == probe_key);
   end

endmodule

// ===== rtl/sks_sequencer.sv =====
// ----------------------------------------------------------------------------
// Sorted key set sequencer
// Walks the store to find the key position; an insert or delete then shifts
// entries one at a time to open or close a slot. One result per transfer.
// ----------------------------------------------------------------------------
module sks_sequencer #(
   parameter int CAPACITY = sks_pkg::CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  sks_pkg::req_type                 req,
   output logic                             busy,
   output logic                             rsp_valid,
   output sks_pkg::rsp_type                 rsp,
   output sks_pkg::mem_ctl_type             mem_ctl,
   output logic [AW-1:0]                    mem_rd_addr,
   output logic [AW-1:0]                    mem_wr_addr,
   output logic signed [sks_pkg::KEY_W-1:0] mem_wr_data,
   input  logic signed [sks_pkg::KEY_W-1:0] mem_rd_data,
   output logic signed [sks_pkg::KEY_W-1:0] cmp_probe,
   input  sks_pkg::cmp_type                 cmp_result
);

   localparam logic [CW:0] CAP_X = (CW+1)'(CAPACITY);

   sks_pkg::seq_state_type state_ff, state_in;
   logic [1:0]                    op_ff, op_in;
   logic signed [sks_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 pos_ff, pos_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          hit_ff, hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sks_pkg::rsp_type              rsp_ff, rsp_in;

   logic [CW:0] idx_x, pos_x, count_x;
   logic [CW:0] idx_dn_x, idx_up_x, idx_up2_x;
   logic        is_insert;

   assign idx_x     = {1'b0, idx_ff};
   assign pos_x     = {1'b0, pos_ff};
   assign count_x   = {1'b0, count_ff};
   assign idx_dn_x  = idx_x - (CW+1)'(1);
   assign idx_up_x  = idx_x + (CW+1)'(1);
   assign idx_up2_x = idx_x + (CW+1)'(2);
   assign is_insert = (op_ff == sks_pkg::OP_INSERT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sks_pkg::SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_ctl.rd_en = 1'b0;
      mem_ctl.wr_en = 1'b0;
      mem_rd_addr   = idx_ff[AW-1:0];
      mem_wr_addr   = idx_ff[AW-1:0];
      mem_wr_data   = mem_rd_data;

      case (state_ff)
         sks_pkg::SEQ_IDLE: begin
            if (start) begin
               op_in    = req.op;
               key_in   = req.key;
               idx_in   = '0;
               state_in = sks_pkg::SEQ_SRCH_RD;
            end
         end
         sks_pkg::SEQ_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               pos_in   = idx_ff;
               hit_in   = 1'b0;
               state_in = sks_pkg::SEQ_DECIDE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = sks_pkg::SEQ_SRCH_CMP;
            end
         end
         sks_pkg::SEQ_SRCH_CMP: begin
            if (cmp_result.lt) begin
               idx_in   = idx_up_x[CW-1:0];
               state_in = sks_pkg::SEQ_SRCH_RD;
            end else begin
               pos_in   = idx_ff;
               hit_in   = cmp_result.eq;
               state_in = sks_pkg::SEQ_DECIDE;
            end
         end
         sks_pkg::SEQ_DECIDE: begin
            state_in = sks_pkg::SEQ_IDLE;
            if (is_insert) begin
               if (hit_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = sks_pkg::ST_DUPLICATE;
                  rsp_in.present = 1'b1;
               end else if (count_x == CAP_X) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = sks_pkg::ST_FULL;
                  rsp_in.present = 1'b0;
               end else begin
                  idx_in = count_ff;
                  if (count_ff == pos_ff) begin
                     state_in = sks_pkg::SEQ_WRITE_KEY;
                  end else begin
                     state_in = sks_pkg::SEQ_SHIFT_RD;
                  end
               end
            end else if (op_ff == sks_pkg::OP_DELETE) begin
               if (!hit_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = sks_pkg::ST_ABSENT;
                  rsp_in.present = 1'b0;
               end else begin
                  idx_in = pos_ff;
                  if (pos_x + (CW+1)'(1) == count_x) begin
                     count_in       = count_ff - CW'(1);
                     rsp_valid_in   = 1'b1;
                     rsp_in.status  = sks_pkg::ST_DELETED;
                     rsp_in.present = 1'b0;
                  end else begin
                     state_in = sks_pkg::SEQ_SHIFT_RD;
                  end
               end
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_in.status  = hit_ff ? sks_pkg::ST_FOUND : sks_pkg::ST_ABSENT;
               rsp_in.present = hit_ff;
            end
         end
         sks_pkg::SEQ_SHIFT_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = is_insert ? idx_dn_x[AW-1:0] : idx_up_x[AW-1:0];
            state_in      = sks_pkg::SEQ_SHIFT_WR;
         end
         sks_pkg::SEQ_SHIFT_WR: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_data   = mem_rd_data;
            if (is_insert) begin
               idx_in = idx_dn_x[CW-1:0];
               if (idx_dn_x == pos_x) begin
                  state_in = sks_pkg::SEQ_WRITE_KEY;
               end else begin
                  state_in = sks_pkg::SEQ_SHIFT_RD;
               end
            end else begin
               idx_in = idx_up_x[CW-1:0];
               if (idx_up2_x == count_x) begin
                  count_in       = count_ff - CW'(1);
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = sks_pkg::ST_DELETED;
                  rsp_in.present = 1'b0;
                  state_in       = sks_pkg::SEQ_IDLE;
               end else begin
                  state_in = sks_pkg::SEQ_SHIFT_RD;
               end
            end
         end
         sks_pkg::SEQ_WRITE_KEY: begin
            mem_ctl.wr_en  = 1'b1;
            mem_wr_addr    = pos_ff[AW-1:0];
            mem_wr_data    = key_ff;
            count_in       = count_ff + CW'(1);
            rsp_valid_in   = 1'b1;
            rsp_in.status  = sks_pkg::ST_INSERTED;
            rsp_in.present = 1'b1;
            state_in       = sks_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = sks_pkg::SEQ_IDLE;
         end
      endcase

      rsp_in.entry_count = 7'(count_in);
   end

   assign busy      = (state_ff != sks_pkg::SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign cmp_probe = key_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= CAP_X)
      else $error("entry count exceeds capacity");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) != sks_pkg::SEQ_IDLE))
      else $error("result strobe without an operation in progress");

   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("entry count changed without a result");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");
`endif

endmodule

// ===== rtl/sorted_key_set_table.sv =====
// ----------------------------------------------------------------------------
// Sorted key set table
// Holds up to CAPACITY distinct signed keys in ascending order and serves
// insert, delete and search requests, one result per request.
// ----------------------------------------------------------------------------
//  Channel   Ports                      Transfer
//  request   start, busy, req           start high while busy low
//  result    rsp_valid, rsp             rsp_valid high for one cycle
//
//  A request reads and compares the stored keys in ascending order up to its
//  position; an insert or delete then moves the entries above it one at a
//  time, each by a read and then a write of the registered key store.
//  Reset is synchronous and empties the set at once; there is no clearing pass.
//  Busy stays high until the result is issued; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_key_set_table #(
   parameter int CAPACITY = sks_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  sks_pkg::req_type req,
   output logic             busy,
   output logic             rsp_valid,
   output sks_pkg::rsp_type rsp
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   sks_pkg::mem_ctl_type             mem_ctl;
   logic [AW-1:0]                    mem_rd_addr;
   logic [AW-1:0]                    mem_wr_addr;
   logic signed [sks_pkg::KEY_W-1:0] mem_wr_data;
   logic signed [sks_pkg::KEY_W-1:0] mem_rd_data;
   logic signed [sks_pkg::KEY_W-1:0] cmp_probe;
   sks_pkg::cmp_type                 cmp_result;

   sks_sequencer #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .mem_ctl     (mem_ctl),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data),
      .cmp_probe   (cmp_probe),
      .cmp_result  (cmp_result)
   );

   sks_key_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   sks_compare u_cmp (
      .stored_key (mem_rd_data),
      .probe_key  (cmp_probe),
      .result     (cmp_result)
   );

endmodule
